[hdl/phong_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// phong_pkg
// Shared types, register codes and log2/exp2 tables for the Phong shader.
// ----------------------------------------------------------------------------
package phong_pkg;

   localparam int FRAC_BITS_DEF = 14;
   localparam int CSR_ADDR_W    = 5;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_DIFFUSE_RED    = 3'd0;
   localparam logic [2:0] REG_DIFFUSE_GREEN  = 3'd1;
   localparam logic [2:0] REG_DIFFUSE_BLUE   = 3'd2;
   localparam logic [2:0] REG_SPECULAR_RED   = 3'd3;
   localparam logic [2:0] REG_SPECULAR_GREEN = 3'd4;
   localparam logic [2:0] REG_SPECULAR_BLUE  = 3'd5;
   localparam logic [2:0] REG_SHININESS      = 3'd6;

   localparam logic [15:0] SHININESS_RST = 16'd256;
   localparam logic [43:0] SAT_INTER     = {44{1'b1}};
   localparam logic [15:0] SAT_OUT       = 16'hFFFF;

   typedef struct packed {
      logic signed [15:0] ray_dir_x;
      logic signed [15:0] ray_dir_y;
      logic signed [15:0] ray_dir_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic signed [15:0] light_dir_x;
      logic signed [15:0] light_dir_y;
      logic signed [15:0] light_dir_z;
      logic [15:0]        light_red;
      logic [15:0]        light_green;
      logic [15:0]        light_blue;
   } req_type;

   typedef struct packed {
      logic [15:0] shade_red;
      logic [15:0] shade_green;
      logic [15:0] shade_blue;
   } rsp_type;

   // log2(1 + i/16) in Q16
   function automatic logic [17:0] log2_entry(input logic [4:0] idx);
      logic [17:0] v;
      unique case (idx)
         5'd0:  v = 18'd0;
         5'd1:  v = 18'd5732;
         5'd2:  v = 18'd11136;
         5'd3:  v = 18'd16248;
         5'd4:  v = 18'd21098;
         5'd5:  v = 18'd25711;
         5'd6:  v = 18'd30109;
         5'd7:  v = 18'd34312;
         5'd8:  v = 18'd38336;
         5'd9:  v = 18'd42196;
         5'd10: v = 18'd45904;
         5'd11: v = 18'd49472;
         5'd12: v = 18'd52911;
         5'd13: v = 18'd56229;
         5'd14: v = 18'd59434;
         5'd15: v = 18'd62534;
         5'd16: v = 18'd65536;
         default: v = 18'd0;
      endcase
      return v;
   endfunction

   // 2^(i/16) in Q16
   function automatic logic [17:0] exp2_entry(input logic [4:0] idx);
      logic [17:0] v;
      unique case (idx)
         5'd0:  v = 18'd65536;
         5'd1:  v = 18'd68438;
         5'd2:  v = 18'd71468;
         5'd3:  v = 18'd74632;
         5'd4:  v = 18'd77936;
         5'd5:  v = 18'd81386;
         5'd6:  v = 18'd84990;
         5'd7:  v = 18'd88753;
         5'd8:  v = 18'd92682;
         5'd9:  v = 18'd96785;
         5'd10: v = 18'd101070;
         5'd11: v = 18'd105545;
         5'd12: v = 18'd110218;
         5'd13: v = 18'd115098;
         5'd14: v = 18'd120194;
         5'd15: v = 18'd125515;
         5'd16: v = 18'd131072;
         default: v = 18'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

[hdl/phong_light_shader.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// phong_light_shader
// Per-light Phong shading of one surface sample, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// One word enters per cycle while req_stall is low and flows through the
// 15-stage pipeline (dot products, reflect, log2/exp2 power, colour products).
// When rsp_stall is high with a result waiting, the whole pipeline holds and
// req_stall rises. Material registers are read directly by the stages, so
// write them only while the block is empty.
module phong_light_shader #(
   parameter int FRAC_BITS = phong_pkg::FRAC_BITS_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  phong_pkg::req_type                 req_data,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output phong_pkg::rsp_type                 rsp_data,
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire [phong_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire [31:0]                         csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   localparam int F        = FRAC_BITS;
   localparam int NST      = 15;
   localparam int NDL_W    = 34 - F;
   localparam int DIF_W    = NDL_W - 1;
   localparam int MP_W     = 16 + NDL_W;
   localparam int RS_W     = MP_W - F + 1;
   localparam int R_W      = ((RS_W > 16) ? RS_W : 16) + 1;
   localparam int VR_W     = 17 + R_W;
   localparam int DV_W     = VR_W + 2;
   localparam int S_W      = DV_W - F - 1;
   localparam int NW       = (S_W > 17) ? S_W : 17;
   localparam int LZ_STEPS = $clog2(NW);
   localparam int LZ_W     = LZ_STEPS + 1;
   localparam int DP_W     = 16 + DIF_W;

   // ---------------- configuration ----------------
   logic [15:0] diff_ff [3];
   logic [15:0] spec_ff [3];
   logic [15:0] shin_ff;
   logic [2:0]  csr_idx;
   logic        csr_wr;

   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            diff_ff[i] <= '0;
            spec_ff[i] <= '0;
         end
         shin_ff <= phong_pkg::SHININESS_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            phong_pkg::REG_DIFFUSE_RED:    diff_ff[0] <= csr_pwdata[15:0];
            phong_pkg::REG_DIFFUSE_GREEN:  diff_ff[1] <= csr_pwdata[15:0];
            phong_pkg::REG_DIFFUSE_BLUE:   diff_ff[2] <= csr_pwdata[15:0];
            phong_pkg::REG_SPECULAR_RED:   spec_ff[0] <= csr_pwdata[15:0];
            phong_pkg::REG_SPECULAR_GREEN: spec_ff[1] <= csr_pwdata[15:0];
            phong_pkg::REG_SPECULAR_BLUE:  spec_ff[2] <= csr_pwdata[15:0];
            phong_pkg::REG_SHININESS:      shin_ff    <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         phong_pkg::REG_DIFFUSE_RED:    csr_prdata = {16'd0, diff_ff[0]};
         phong_pkg::REG_DIFFUSE_GREEN:  csr_prdata = {16'd0, diff_ff[1]};
         phong_pkg::REG_DIFFUSE_BLUE:   csr_prdata = {16'd0, diff_ff[2]};
         phong_pkg::REG_SPECULAR_RED:   csr_prdata = {16'd0, spec_ff[0]};
         phong_pkg::REG_SPECULAR_GREEN: csr_prdata = {16'd0, spec_ff[1]};
         phong_pkg::REG_SPECULAR_BLUE:  csr_prdata = {16'd0, spec_ff[2]};
         phong_pkg::REG_SHININESS:      csr_prdata = {16'd0, shin_ff};
         default:                       csr_prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------
   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_in;
   logic           en;

   assign en        = !(vld_ff[NST-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[NST-1];
   assign vld_in    = {vld_ff[NST-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------- datapath registers ----------------
   phong_pkg::req_type  req_pipe_ff   [1:4];
   logic [2:0][15:0]    light_pipe_ff [1:13];
   logic [DIF_W-1:0]    dif_pipe_ff   [2:11];
   logic                szero_pipe_ff [6:10];

   logic signed [31:0]      nl_ff  [3];
   logic signed [NDL_W-1:0] ndl_ff;
   logic signed [MP_W-1:0]  rp_ff  [3];
   logic signed [R_W-1:0]   r_ff   [3];
   logic signed [VR_W-1:0]  vr_ff  [3];
   logic [S_W-1:0]          s_ff;
   logic signed [7:0]       pf_ff;
   logic [15:0]             m_ff;
   logic signed [23:0]      lg_ff;
   logic [32:0]             y_ff;
   logic [17:0]             ex_ff;
   logic [17:0]             sh_ff;
   logic [43:0]             pw_ff;
   logic [DP_W-1:0]         dp_ff  [3];
   logic [37:0]             sp_lo_ff [3];
   logic [37:0]             sp_hi_ff [3];
   logic [43:0]             sum_ff [3];
   logic [37:0]             lp_lo_ff [3];
   logic [37:0]             lp_hi_ff [3];
   logic [15:0]             out_ff [3];

   // ---------------- next-value logic ----------------
   logic signed [15:0]      nrm0 [3];
   logic signed [15:0]      lt0  [3];
   logic signed [15:0]      nrm2 [3];
   logic signed [15:0]      lt3  [3];
   logic signed [15:0]      dir4 [3];
   logic [2:0][15:0]        light0;

   assign nrm0[0] = req_data.normal_x;
   assign nrm0[1] = req_data.normal_y;
   assign nrm0[2] = req_data.normal_z;
   assign lt0[0]  = req_data.light_dir_x;
   assign lt0[1]  = req_data.light_dir_y;
   assign lt0[2]  = req_data.light_dir_z;
   assign nrm2[0] = req_pipe_ff[2].normal_x;
   assign nrm2[1] = req_pipe_ff[2].normal_y;
   assign nrm2[2] = req_pipe_ff[2].normal_z;
   assign lt3[0]  = req_pipe_ff[3].light_dir_x;
   assign lt3[1]  = req_pipe_ff[3].light_dir_y;
   assign lt3[2]  = req_pipe_ff[3].light_dir_z;
   assign dir4[0] = req_pipe_ff[4].ray_dir_x;
   assign dir4[1] = req_pipe_ff[4].ray_dir_y;
   assign dir4[2] = req_pipe_ff[4].ray_dir_z;
   assign light0  = {req_data.light_blue, req_data.light_green, req_data.light_red};

   logic signed [31:0]      nl_in  [3];
   logic signed [33:0]      dnl;
   logic signed [NDL_W-1:0] ndl_in;
   logic [DIF_W-1:0]        dif_in;
   logic signed [MP_W-1:0]  rp_in  [3];
   logic signed [R_W-1:0]   r_in   [3];
   logic signed [16:0]      v4     [3];
   logic signed [VR_W-1:0]  vr_in  [3];
   logic signed [DV_W-1:0]  dvr;
   logic [S_W:0]            spc;
   logic [S_W-1:0]          s_in;
   logic                    szero_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nl_in[i] = nrm0[i] * lt0[i];
         rp_in[i] = nrm2[i] * ndl_ff;
         r_in[i]  = R_W'($signed(rp_ff[i][MP_W-1:F-1])) - R_W'(lt3[i]);
         v4[i]    = 17'sd0 - 17'(dir4[i]);
         vr_in[i] = v4[i] * r_ff[i];
      end
      dnl    = 34'(nl_ff[0]) + 34'(nl_ff[1]) + 34'(nl_ff[2]);
      ndl_in = dnl[33:F];
      dif_in = ndl_in[NDL_W-1] ? '0 : ndl_in[NDL_W-2:0];
      dvr    = DV_W'(vr_ff[0]) + DV_W'(vr_ff[1]) + DV_W'(vr_ff[2]);
      spc    = dvr[DV_W-1:F];
      s_in   = spc[S_W] ? '0 : spc[S_W-1:0];
      szero_in = (s_in == '0);
   end

   // leading-one search, halving steps
   logic [NW-1:0]     nx;
   logic [LZ_W-1:0]   lz;
   logic signed [7:0] pf_in;
   logic [15:0]       m_in;

   always_comb begin
      nx = NW'(s_ff);
      lz = '0;
      for (int k = LZ_STEPS - 1; k >= 0; k--) begin
         if ((nx >> (NW - (1 << k))) == '0) begin
            nx = nx << (1 << k);
            lz = lz + LZ_W'(1 << k);
         end
      end
      pf_in = 8'(NW - 1 - F) - 8'(lz);
      m_in  = nx[NW-2 -: 16];
   end

   // log2 interpolation
   logic [17:0]        lg_a, lg_b, li;
   logic [29:0]        lg_x;
   logic signed [23:0] lg_in;

   always_comb begin
      lg_a  = phong_pkg::log2_entry({1'b0, m_ff[15:12]});
      lg_b  = phong_pkg::log2_entry(5'({1'b0, m_ff[15:12]}) + 5'd1);
      lg_x  = 30'(lg_b - lg_a) * 30'(m_ff[11:0]);
      li    = lg_a + 18'(lg_x >> 12);
      lg_in = $signed({pf_ff, 16'd0}) + $signed({6'd0, li});
   end

   // times exponent, Q16 result
   logic signed [40:0] yp;
   always_comb begin
      yp = lg_ff * $signed({1'b0, shin_ff});
   end

   // exp2 interpolation and scale
   logic signed [16:0] yn;
   logic [17:0]        ex_a, ex_b, ex_in, sh_in;
   logic [29:0]        ex_x;

   always_comb begin
      yn    = y_ff[32:16];
      ex_a  = phong_pkg::exp2_entry({1'b0, y_ff[15:12]});
      ex_b  = phong_pkg::exp2_entry(5'({1'b0, y_ff[15:12]}) + 5'd1);
      ex_x  = 30'(ex_b - ex_a) * 30'(y_ff[11:0]);
      ex_in = ex_a + 18'(ex_x >> 12);
      sh_in = 18'(yn) + 18'(F) - 18'd16;
   end

   // power result with saturation
   logic [17:0] nsh;
   logic [44:0] shl;
   logic [43:0] pw_in;

   always_comb begin
      nsh = 18'd0 - sh_ff;
      shl = 45'(ex_ff) << sh_ff[4:0];
      priority if (shin_ff == '0) begin
         pw_in = 44'(1) << F;
      end else if (szero_pipe_ff[10]) begin
         pw_in = '0;
      end else if (!sh_ff[17] && (sh_ff[16:0] >= 17'd28)) begin
         pw_in = phong_pkg::SAT_INTER;
      end else if (!sh_ff[17]) begin
         pw_in = (shl > 45'(phong_pkg::SAT_INTER)) ? phong_pkg::SAT_INTER : shl[43:0];
      end else if (nsh >= 18'd18) begin
         pw_in = '0;
      end else begin
         pw_in = 44'(ex_ff >> nsh[4:0]);
      end
   end

   // colour products; 44-bit operands split in two halves
   logic [DP_W-1:0] dp_in    [3];
   logic [37:0]     sp_lo_in [3];
   logic [37:0]     sp_hi_in [3];
   logic [59:0]     spf      [3];
   logic [60:0]     tot      [3];
   logic [43:0]     sum_in   [3];
   logic [37:0]     lp_lo_in [3];
   logic [37:0]     lp_hi_in [3];
   logic [59:0]     lpf      [3];
   logic [59:0]     lsc      [3];
   logic [15:0]     out_in   [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dp_in[i]    = DP_W'(diff_ff[i]) * DP_W'(dif_pipe_ff[11]);
         sp_lo_in[i] = 38'(spec_ff[i]) * 38'(pw_ff[21:0]);
         sp_hi_in[i] = 38'(spec_ff[i]) * 38'(pw_ff[43:22]);
         spf[i]      = {sp_hi_ff[i], 22'd0} + 60'(sp_lo_ff[i]);
         tot[i]      = 61'(spf[i] >> F) + 61'(dp_ff[i] >> F);
         sum_in[i]   = (tot[i] > 61'(phong_pkg::SAT_INTER)) ?
                       phong_pkg::SAT_INTER : tot[i][43:0];
         lp_lo_in[i] = 38'(sum_ff[i][21:0]) * 38'(light_pipe_ff[13][i]);
         lp_hi_in[i] = 38'(sum_ff[i][43:22]) * 38'(light_pipe_ff[13][i]);
         lpf[i]      = {lp_hi_ff[i], 22'd0} + 60'(lp_lo_ff[i]);
         lsc[i]      = lpf[i] >> F;
         out_in[i]   = (lsc[i] > 60'(phong_pkg::SAT_OUT)) ? phong_pkg::SAT_OUT : lsc[i][15:0];
      end
   end

   // ---------------- pipeline registers ----------------
   always_ff @(posedge clock) begin
      if (en) begin
         req_pipe_ff[1]   <= req_data;
         light_pipe_ff[1] <= light0;
         for (int k = 2; k <= 4; k++) req_pipe_ff[k] <= req_pipe_ff[k-1];
         for (int k = 2; k <= 13; k++) light_pipe_ff[k] <= light_pipe_ff[k-1];
         dif_pipe_ff[2] <= dif_in;
         for (int k = 3; k <= 11; k++) dif_pipe_ff[k] <= dif_pipe_ff[k-1];
         szero_pipe_ff[6] <= szero_in;
         for (int k = 7; k <= 10; k++) szero_pipe_ff[k] <= szero_pipe_ff[k-1];
         for (int i = 0; i < 3; i++) begin
            nl_ff[i]    <= nl_in[i];
            rp_ff[i]    <= rp_in[i];
            r_ff[i]     <= r_in[i];
            vr_ff[i]    <= vr_in[i];
            dp_ff[i]    <= dp_in[i];
            sp_lo_ff[i] <= sp_lo_in[i];
            sp_hi_ff[i] <= sp_hi_in[i];
            sum_ff[i]   <= sum_in[i];
            lp_lo_ff[i] <= lp_lo_in[i];
            lp_hi_ff[i] <= lp_hi_in[i];
            out_ff[i]   <= out_in[i];
         end
         ndl_ff <= ndl_in;
         s_ff   <= s_in;
         pf_ff  <= pf_in;
         m_ff   <= m_in;
         lg_ff  <= lg_in;
         y_ff   <= yp[40:8];
         ex_ff  <= ex_in;
         sh_ff  <= sh_in;
         pw_ff  <= pw_in;
      end
   end

   assign rsp_data.shade_red   = out_ff[0];
   assign rsp_data.shade_green = out_ff[1];
   assign rsp_data.shade_blue  = out_ff[2];

endmodule
`default_nettype wire

[dv/phong_checker.sv]
// ----------------------------------------------------------------------------
// phong_checker
// Watches both word channels of the shader, predicts each shade from the
// accepted request and the material registers, and compares in order.
// ----------------------------------------------------------------------------
module phong_checker (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   input  wire                req_stall,
   input  phong_pkg::req_type req_data,
   input  wire                rsp_valid,
   input  wire                rsp_stall,
   input  phong_pkg::rsp_type rsp_data,
   input  wire                csr_psel,
   input  wire                csr_penable,
   input  wire                csr_pwrite,
   input  wire [4:0]          csr_paddr,
   input  wire [31:0]         csr_pwdata,
   input  wire                csr_pready,
   output int                 fail_count,
   output int                 pending_shades
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB = phong_pkg::FRAC_BITS_DEF;
   localparam longint SAT44 = (64'd1 << 44) - 1;

   logic [15:0] mat_diff [3];
   logic [15:0] mat_spec [3];
   logic [15:0] mat_shin;
   phong_pkg::rsp_type shade_queue [$];

   longint log_tab [17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
      42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};
   longint exp_tab [17] = '{65536, 68438, 71468, 74632, 77936, 81386, 84990, 88753,
      92682, 96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072};

   // floor shift; >>> on a signed longint is already a floor
   function automatic longint floor_shr(longint x, int s);
      return x >>> s;
   endfunction

   function automatic longint tab_lerp(int sel, longint f16);
      longint i, fr, a, b;
      i = (f16 >> 12) & 15;
      fr = f16 & 12'hFFF;
      a = sel ? exp_tab[i] : log_tab[i];
      b = sel ? exp_tab[i+1] : log_tab[i+1];
      return a + (((b - a) * fr) >> 12);
   endfunction

   function automatic longint spec_power(longint s, longint e);
      int p;
      longint t, m, lg, y, n, ex, sh, r;
      if (e == 0) return 64'd1 << FB;
      if (s == 0) return 0;
      p = 0;
      t = s;
      while (t > 1) begin
         t = t >> 1;
         p++;
      end
      m = (p >= 16) ? (s >> (p - 16)) : (s << (16 - p));
      m = m & 16'hFFFF;
      lg = (longint'(p) - FB) * 65536 + tab_lerp(0, m);
      y = floor_shr(lg * e, 8);
      n = floor_shr(y, 16);
      ex = tab_lerp(1, y - n * 65536);
      sh = n + FB - 16;
      if (sh >= 28) return SAT44;
      if (sh >= 0) begin
         r = ex << sh;
         return (r > SAT44) ? SAT44 : r;
      end
      if (sh <= -63) return 0;
      return ex >> (-sh);
   endfunction

   function automatic phong_pkg::rsp_type shade_of(phong_pkg::req_type q);
      longint v [3], nv [3], lv [3], rv [3], lc [3];
      longint dnl, dvr, ndl, dif, spc, pw, sum, prod;
      phong_pkg::rsp_type o;
      v[0] = -longint'(q.ray_dir_x);  v[1] = -longint'(q.ray_dir_y);
      v[2] = -longint'(q.ray_dir_z);
      nv[0] = q.normal_x;    nv[1] = q.normal_y;    nv[2] = q.normal_z;
      lv[0] = q.light_dir_x; lv[1] = q.light_dir_y; lv[2] = q.light_dir_z;
      lc[0] = q.light_red;   lc[1] = q.light_green; lc[2] = q.light_blue;
      dnl = 0;
      dvr = 0;
      for (int i = 0; i < 3; i++) dnl += nv[i] * lv[i];
      ndl = floor_shr(dnl, FB);
      for (int i = 0; i < 3; i++) begin
         rv[i] = floor_shr(nv[i] * ndl, FB - 1) - lv[i];
         dvr += v[i] * rv[i];
      end
      dif = (ndl < 0) ? 0 : ndl;
      spc = floor_shr(dvr, FB);
      if (spc < 0) spc = 0;
      pw = spec_power(spc, mat_shin);
      for (int i = 0; i < 3; i++) begin
         sum = ((longint'(mat_diff[i]) * dif) >> FB) + ((longint'(mat_spec[i]) * pw) >> FB);
         if (sum > SAT44) sum = SAT44;
         prod = (sum * lc[i]) >> FB;
         if (prod > 65535) prod = 65535;
         case (i)
            0: o.shade_red = prod[15:0];
            1: o.shade_green = prod[15:0];
            default: o.shade_blue = prod[15:0];
         endcase
      end
      return o;
   endfunction

   assign pending_shades = shade_queue.size();

   always @(posedge clock) begin
      phong_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            mat_diff[i] <= '0;
            mat_spec[i] <= '0;
         end
         mat_shin <= phong_pkg::SHININESS_RST;
         fail_count <= 0;
         shade_queue.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               phong_pkg::REG_DIFFUSE_RED:    mat_diff[0] <= csr_pwdata[15:0];
               phong_pkg::REG_DIFFUSE_GREEN:  mat_diff[1] <= csr_pwdata[15:0];
               phong_pkg::REG_DIFFUSE_BLUE:   mat_diff[2] <= csr_pwdata[15:0];
               phong_pkg::REG_SPECULAR_RED:   mat_spec[0] <= csr_pwdata[15:0];
               phong_pkg::REG_SPECULAR_GREEN: mat_spec[1] <= csr_pwdata[15:0];
               phong_pkg::REG_SPECULAR_BLUE:  mat_spec[2] <= csr_pwdata[15:0];
               phong_pkg::REG_SHININESS:      mat_shin <= csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) shade_queue.push_back(shade_of(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (shade_queue.size() == 0) begin
               $display("%0t: unexpected shade word %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = shade_queue.pop_front();
               if (want !== rsp_data) begin
                  $display("%0t: shade mismatch expected %h actual %h",
                     $time, want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives shading samples and material settings into the Phong shader with
// random idling on both sides; verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG = 20000;
   localparam int ONE = 16384;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   phong_pkg::req_type req_data;
   phong_pkg::rsp_type rsp_data;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [4:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   int fail_count, pending_shades;
   int send_idle, recv_idle, quiet_cycles;

   phong_light_shader uut (.*);
   phong_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= {16'h0, val};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   task automatic drain;
      req_valid <= 0;
      while (pending_shades != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_material(logic [15:0] d[3], logic [15:0] s[3], logic [15:0] e);
      drain();
      for (int i = 0; i < 3; i++) begin
         csr_write(phong_pkg::REG_DIFFUSE_RED + 3'(i), d[i]);
         csr_write(phong_pkg::REG_SPECULAR_RED + 3'(i), s[i]);
      end
      csr_write(phong_pkg::REG_SHININESS, e);
   endtask

   // valid stays high after the accepting edge; the next word or idle cycle
   // drives it again in the same time step
   task automatic send_word(phong_pkg::req_type w);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_comp(int mode);
      int k;
      k = $urandom_range(3);
      if (mode == 0 || k == 0) return 16'($urandom);
      return 16'($urandom_range(2 * ONE) - ONE);
   endfunction

   // mostly near-unit, sensible geometry; some raw noise
   function automatic phong_pkg::req_type random_sample();
      phong_pkg::req_type w;
      int mode;
      mode = $urandom_range(4);
      w.ray_dir_x = pick_comp(mode); w.ray_dir_y = pick_comp(mode);
      w.ray_dir_z = pick_comp(mode);
      w.normal_x = pick_comp(mode); w.normal_y = pick_comp(mode);
      w.normal_z = pick_comp(mode);
      w.light_dir_x = pick_comp(mode); w.light_dir_y = pick_comp(mode);
      w.light_dir_z = pick_comp(mode);
      if (mode == 1) begin
         // mirror geometry: strong specular highlight
         w.normal_x = 16'sd0; w.normal_y = 16'sd0; w.normal_z = 16'(ONE);
         w.light_dir_z = 16'($urandom_range(ONE));
         w.ray_dir_x = w.light_dir_x; w.ray_dir_y = w.light_dir_y;
         w.ray_dir_z = -w.light_dir_z;
      end
      w.light_red = 16'($urandom); w.light_green = 16'($urandom);
      w.light_blue = 16'($urandom);
      return w;
   endfunction

   function automatic phong_pkg::req_type vec_sample(int r, int n, int l, logic [15:0] c);
      phong_pkg::req_type w;
      w.ray_dir_x = 16'sd0; w.ray_dir_y = 16'sd0; w.ray_dir_z = 16'(r);
      w.normal_x = 16'sd0; w.normal_y = 16'sd0; w.normal_z = 16'(n);
      w.light_dir_x = 16'sd0; w.light_dir_y = 16'sd0; w.light_dir_z = 16'(l);
      w.light_red = c; w.light_green = c; w.light_blue = c;
      return w;
   endfunction

   initial begin
      logic [15:0] d[3], s[3];
      phong_pkg::req_type w;
      reset = 1; req_valid = 0; req_data = '0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = '0; csr_pwdata = '0;
      send_idle = 0; recv_idle = 0;
      repeat (9) @(posedge clock);
      reset <= 0;

      // directed: reset material, then full scale with zero exponent
      send_word(vec_sample(-ONE, ONE, ONE, 16'hFFFF));
      d = '{16'hFFFF, 16'hFFFF, 16'hFFFF}; s = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
      set_material(d, s, 16'd0);
      send_word(vec_sample(0, ONE, 0, 16'(ONE)));          // zero to the power zero
      send_word(vec_sample(-ONE, ONE, -ONE, 16'(ONE)));    // back-facing light
      send_word(vec_sample(ONE, ONE, ONE, 16'hFFFF));      // back-facing view
      w = '1; w.ray_dir_x = 16'h8000; send_word(w);
      w = '0; w.normal_x = 16'h7FFF; w.light_dir_x = 16'h7FFF; send_word(w);
      set_material(d, s, 16'hFFFF);                        // huge power saturates
      send_word(vec_sample(-32768, 32767, 32767, 16'hFFFF));
      send_word(vec_sample(-ONE, ONE, ONE, 16'hFFFF));
      send_word(vec_sample(-2000, ONE, 2000, 16'hFFFF));   // tiny power
      send_word(vec_sample(0, ONE, 0, 16'(ONE)));          // zero base, e > 0
      d = '{16'd0, 16'd1234, 16'h8000}; s = '{16'h4000, 16'd0, 16'hFFFF};
      set_material(d, s, 16'd1);
      for (int i = 0; i < 8; i++) send_word(random_sample());

      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 6 : (ph == 1) ? 59 : 0;
         recv_idle = (ph == 0) ? 59 : (ph == 1) ? 6 : 0;
         for (int k = 0; k < 5; k++) begin
            for (int i = 0; i < 3; i++) begin
               d[i] = $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom);
               s[i] = $urandom_range(3) == 0 ? 16'd0 : 16'($urandom);
            end
            set_material(d, s, $urandom_range(3) == 0 ? 16'($urandom) :
                         16'($urandom_range(8192)));
            for (int i = 0; i < 108; i++) send_word(random_sample());
         end
      end
      drain();
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule

[sim.f]
hdl/phong_pkg.sv
hdl/phong_light_shader.sv
dv/phong_checker.sv
dv/testbench.sv
